[hw/rtl/irled_pkg.sv]
// Shared types, key codes and reset constants for the IR RGB LED mode controller.
package irled_pkg;

  // Item kinds on the input channel.
  localparam logic OPER_KEY  = 1'b0;
  localparam logic OPER_TICK = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_PERIOD       = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_BRIGHTNESS_STEP   = 8'd20;
  localparam logic [15:0] RST_SMOOTH_PERIOD     = 16'd6;
  localparam logic [15:0] RST_FLASH_HALF_PERIOD = 16'd501;
  localparam logic [15:0] RST_FADE_PERIOD       = 16'd2;

  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam logic [7:0]  LEVEL_MAX = 8'd255;

  // Remote key codes.
  localparam logic [15:0] KEY_ON      = 16'h00FF;
  localparam logic [15:0] KEY_OFF     = 16'h807F;
  localparam logic [15:0] KEY_YELLOW  = 16'h40BF;
  localparam logic [15:0] KEY_BLUE    = 16'h20DF;
  localparam logic [15:0] KEY_PINK    = 16'hA05F;
  localparam logic [15:0] KEY_LILAC   = 16'h609F;
  localparam logic [15:0] KEY_TEAL    = 16'h10EF;
  localparam logic [15:0] KEY_ORANGE  = 16'h906F;
  localparam logic [15:0] KEY_MAGENTA = 16'h50AF;
  localparam logic [15:0] KEY_CYAN    = 16'h30CF;
  localparam logic [15:0] KEY_AMBER   = 16'hB04F;
  localparam logic [15:0] KEY_PURPLE  = 16'h708F;
  localparam logic [15:0] KEY_MINT    = 16'h08F7;
  localparam logic [15:0] KEY_CORAL   = 16'h8877;
  localparam logic [15:0] KEY_WHITE_W = 16'h48B7;
  localparam logic [15:0] KEY_STROBE  = 16'h28D7;
  localparam logic [15:0] KEY_FADE    = 16'hA857;
  localparam logic [15:0] KEY_SMOOTH  = 16'h6897;
  localparam logic [15:0] KEY_FLASH   = 16'h18E7;
  localparam logic [15:0] KEY_DIM     = 16'h9867;
  localparam logic [15:0] KEY_BRIGHT  = 16'h58A7;

  // Action decoded from one key code.
  typedef enum logic [3:0] {
    KOP_NONE,
    KOP_SET_RGB,
    KOP_OFF,
    KOP_STROBE,
    KOP_FADE,
    KOP_SMOOTH,
    KOP_FLASH,
    KOP_DIM,
    KOP_BRIGHT
  } key_op_t;

  typedef struct packed {
    logic       matched;
    key_op_t    op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } key_cmd_t;

  typedef struct packed {
    logic [7:0]  brightness_step;
    logic [15:0] smooth_period;
    logic [15:0] flash_half_period;
    logic [15:0] fade_period;
  } cfg_t;

  typedef struct packed {
    logic fade;
    logic smooth;
    logic strobe;
    logic flash;
  } mode_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       code_matched;
    logic       fading_active;
  } result_t;

endpackage

[hw/rtl/irled_key_decode.sv]
// Key code decoder: maps a remote key code to an action and preset color.
module irled_key_decode (
  input  logic [15:0]        key_code,
  output irled_pkg::key_cmd_t cmd
);

  // Table lookup; unknown codes come out unmatched with no action.
  always_comb begin
    cmd = '{matched: 1'b1, op: irled_pkg::KOP_SET_RGB, red: 8'd0, green: 8'd0, blue: 8'd0};
    case (key_code)
      irled_pkg::KEY_ON:      begin cmd.red = 8'd255; cmd.green = 8'd255; cmd.blue = 8'd255; end
      irled_pkg::KEY_OFF:     cmd.op = irled_pkg::KOP_OFF;
      irled_pkg::KEY_YELLOW:  begin cmd.red = 8'd255; cmd.green = 8'd246; cmd.blue = 8'd0; end
      irled_pkg::KEY_BLUE:    begin cmd.red = 8'd0; cmd.green = 8'd0; cmd.blue = 8'd255; end
      irled_pkg::KEY_PINK:    begin cmd.red = 8'd255; cmd.green = 8'd219; cmd.blue = 8'd232; end
      irled_pkg::KEY_LILAC:   begin cmd.red = 8'd209; cmd.green = 8'd117; cmd.blue = 8'd255; end
      irled_pkg::KEY_TEAL:    begin cmd.red = 8'd0; cmd.green = 8'd117; cmd.blue = 8'd175; end
      irled_pkg::KEY_ORANGE:  begin cmd.red = 8'd255; cmd.green = 8'd153; cmd.blue = 8'd0; end
      irled_pkg::KEY_MAGENTA: begin cmd.red = 8'd255; cmd.green = 8'd0; cmd.blue = 8'd255; end
      irled_pkg::KEY_CYAN:    begin cmd.red = 8'd0; cmd.green = 8'd203; cmd.blue = 8'd255; end
      irled_pkg::KEY_AMBER:   begin cmd.red = 8'd255; cmd.green = 8'd110; cmd.blue = 8'd0; end
      irled_pkg::KEY_PURPLE:  begin cmd.red = 8'd116; cmd.green = 8'd37; cmd.blue = 8'd252; end
      irled_pkg::KEY_MINT:    begin cmd.red = 8'd38; cmd.green = 8'd255; cmd.blue = 8'd139; end
      irled_pkg::KEY_CORAL:   begin cmd.red = 8'd255; cmd.green = 8'd58; cmd.blue = 8'd58; end
      irled_pkg::KEY_WHITE_W: cmd.op = irled_pkg::KOP_NONE;
      irled_pkg::KEY_STROBE:  cmd.op = irled_pkg::KOP_STROBE;
      irled_pkg::KEY_FADE:    cmd.op = irled_pkg::KOP_FADE;
      irled_pkg::KEY_SMOOTH:  cmd.op = irled_pkg::KOP_SMOOTH;
      irled_pkg::KEY_FLASH:   cmd.op = irled_pkg::KOP_FLASH;
      irled_pkg::KEY_DIM:     cmd.op = irled_pkg::KOP_DIM;
      irled_pkg::KEY_BRIGHT:  cmd.op = irled_pkg::KOP_BRIGHT;
      default: begin
        cmd.matched = 1'b0;
        cmd.op      = irled_pkg::KOP_NONE;
      end
    endcase
  end

endmodule

[hw/rtl/irled_state.sv]
// Mode and color state with the per-item update and the duty output mux.
module irled_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 operation,
  input  irled_pkg::key_cmd_t  cmd,
  input  irled_pkg::cfg_t      cfg,
  output irled_pkg::result_t   res
);

  logic [2:0][7:0]  lvl_r, lvl_nxt;
  logic [2:0]       dir_r, dir_nxt;
  irled_pkg::mode_t mode_r, mode_nxt;
  logic             phase_r, phase_nxt;
  logic [15:0]      smooth_cnt_r, smooth_cnt_nxt;
  logic [15:0]      flash_cnt_r, flash_cnt_nxt;
  logic [15:0]      fade_cnt_r, fade_cnt_nxt;
  logic [15:0]      smooth_inc, flash_inc, fade_inc;
  logic             is_black, matched, show_alt;

  // Saturating tick counters.
  assign smooth_inc = (smooth_cnt_r == irled_pkg::CNT_MAX) ? smooth_cnt_r : smooth_cnt_r + 16'd1;
  assign flash_inc  = (flash_cnt_r == irled_pkg::CNT_MAX) ? flash_cnt_r : flash_cnt_r + 16'd1;
  assign fade_inc   = (fade_cnt_r == irled_pkg::CNT_MAX) ? fade_cnt_r : fade_cnt_r + 16'd1;
  assign is_black   = (lvl_r == '0);

  // Next state for one item: a tick advances the timers, a key applies its action.
  always_comb begin
    logic [8:0] sum;
    lvl_nxt        = lvl_r;
    dir_nxt        = dir_r;
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    smooth_cnt_nxt = smooth_cnt_r;
    flash_cnt_nxt  = flash_cnt_r;
    fade_cnt_nxt   = fade_cnt_r;
    matched        = 1'b0;
    sum            = '0;
    if (operation == irled_pkg::OPER_TICK) begin
      // Flash phase toggles every half period.
      if (flash_inc >= cfg.flash_half_period) begin
        flash_cnt_nxt = '0;
        phase_nxt     = ~phase_r;
      end else begin
        flash_cnt_nxt = flash_inc;
      end
      // Triangle step of each channel, paused during fade.
      smooth_cnt_nxt = smooth_inc;
      if (mode_r.smooth && !mode_r.fade && smooth_inc >= cfg.smooth_period) begin
        smooth_cnt_nxt = '0;
        for (int i = 0; i < 3; i++) begin
          if (dir_r[i]) begin
            if (lvl_r[i] == irled_pkg::LEVEL_MAX) dir_nxt[i] = 1'b0;
            else lvl_nxt[i] = lvl_r[i] + 8'd1;
          end else begin
            if (lvl_r[i] == 8'd0) dir_nxt[i] = 1'b1;
            else lvl_nxt[i] = lvl_r[i] - 8'd1;
          end
        end
      end
      // Fade lowers every nonzero channel once per period and ends at black.
      if (mode_r.fade) begin
        if (fade_inc >= cfg.fade_period) begin
          fade_cnt_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            if (lvl_r[i] != 8'd0) lvl_nxt[i] = lvl_r[i] - 8'd1;
          end
        end else begin
          fade_cnt_nxt = fade_inc;
        end
        if (lvl_nxt == '0) mode_nxt.fade = 1'b0;
      end
    end else if (!mode_r.fade) begin
      matched = cmd.matched;
      case (cmd.op)
        irled_pkg::KOP_SET_RGB: lvl_nxt = {cmd.blue, cmd.green, cmd.red};
        irled_pkg::KOP_OFF: begin
          lvl_nxt         = '0;
          mode_nxt.flash  = 1'b0;
          mode_nxt.smooth = 1'b0;
        end
        irled_pkg::KOP_STROBE: begin
          mode_nxt.flash  = 1'b0;
          mode_nxt.smooth = 1'b0;
          mode_nxt.strobe = 1'b1;
          lvl_nxt         = {8'd255, 8'd0, 8'd0};
        end
        irled_pkg::KOP_FADE: begin
          if (!is_black) begin
            mode_nxt.fade = 1'b1;
            fade_cnt_nxt  = '0;
          end
        end
        irled_pkg::KOP_SMOOTH: begin
          mode_nxt.smooth = ~mode_r.smooth;
          if (!mode_r.smooth && is_black) lvl_nxt = {8'd252, 8'd37, 8'd116};
        end
        irled_pkg::KOP_FLASH: begin
          mode_nxt.strobe = 1'b0;
          mode_nxt.flash  = ~mode_r.flash;
          if (!mode_r.flash && is_black) lvl_nxt = {8'd255, 8'd255, 8'd255};
        end
        irled_pkg::KOP_DIM: begin
          for (int i = 0; i < 3; i++) begin
            lvl_nxt[i] = (lvl_r[i] > cfg.brightness_step) ? lvl_r[i] - cfg.brightness_step
                                                          : 8'd0;
          end
        end
        irled_pkg::KOP_BRIGHT: begin
          for (int i = 0; i < 3; i++) begin
            sum        = {1'b0, lvl_r[i]} + {1'b0, cfg.brightness_step};
            lvl_nxt[i] = sum[8] ? irled_pkg::LEVEL_MAX : sum[7:0];
          end
        end
        default: lvl_nxt = lvl_r;
      endcase
    end
  end

  // Duties follow the updated state; flash blanks and strobe shows red in phase one.
  assign show_alt          = (mode_nxt.flash || mode_nxt.strobe) && phase_nxt;
  assign res.red           = show_alt ? (mode_nxt.strobe ? irled_pkg::LEVEL_MAX : 8'd0)
                                      : lvl_nxt[0];
  assign res.green         = show_alt ? 8'd0 : lvl_nxt[1];
  assign res.blue          = show_alt ? 8'd0 : lvl_nxt[2];
  assign res.code_matched  = matched;
  assign res.fading_active = mode_nxt.fade;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r        <= '0;
      dir_r        <= 3'b111;
      mode_r       <= '0;
      phase_r      <= 1'b0;
      smooth_cnt_r <= '0;
      flash_cnt_r  <= '0;
      fade_cnt_r   <= '0;
    end else if (step_en) begin
      lvl_r        <= lvl_nxt;
      dir_r        <= dir_nxt;
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      smooth_cnt_r <= smooth_cnt_nxt;
      flash_cnt_r  <= flash_cnt_nxt;
      fade_cnt_r   <= fade_cnt_nxt;
    end
  end

endmodule

[hw/rtl/ir_rgb_led_mode_controller_core.sv]
// Flow: an accepted item is held in the input register and then registered as a result
// in the result register; the mode state is updated in the same cycle that fills it.
// Throughput: one item per cycle while results are taken; the input register and the
// result register each hold one item.
// Reset: synchronous, active low; clears levels, modes, counters and both valid flags,
// sets all channel directions to rising and loads the register defaults.
module ir_rgb_led_mode_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [15:0]                     in_key_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red_duty,
  output logic [7:0]                      out_green_duty,
  output logic [7:0]                      out_blue_duty,
  output logic                            out_code_matched,
  output logic                            out_fading_active,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irled_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  irled_pkg::cfg_t     cfg_r;
  irled_pkg::key_cmd_t cmd;
  irled_pkg::result_t  res;
  irled_pkg::result_t  out_r;
  logic                s1_valid_r;
  logic                s1_op_r;
  logic [15:0]         s1_key_r;
  logic                out_valid_r;
  logic                advance;

  // The held item moves into the result register when that register is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op_r  <= in_operation;
      s1_key_r <= in_key_code;
    end
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness_step   <= irled_pkg::RST_BRIGHTNESS_STEP;
      cfg_r.smooth_period     <= irled_pkg::RST_SMOOTH_PERIOD;
      cfg_r.flash_half_period <= irled_pkg::RST_FLASH_HALF_PERIOD;
      cfg_r.fade_period       <= irled_pkg::RST_FADE_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        irled_pkg::CFG_BRIGHTNESS_STEP:   cfg_r.brightness_step   <= cfg_data[7:0];
        irled_pkg::CFG_SMOOTH_PERIOD:     cfg_r.smooth_period     <= cfg_data;
        irled_pkg::CFG_FLASH_HALF_PERIOD: cfg_r.flash_half_period <= cfg_data;
        irled_pkg::CFG_FADE_PERIOD:       cfg_r.fade_period       <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  irled_key_decode u_key_decode (
    .key_code (s1_key_r),
    .cmd      (cmd)
  );

  irled_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .operation (s1_op_r),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red_duty      = out_r.red;
  assign out_green_duty    = out_r.green;
  assign out_blue_duty     = out_r.blue;
  assign out_code_matched  = out_r.code_matched;
  assign out_fading_active = out_r.fading_active;

endmodule

[hw/rtl/irled_checker.sv]
// Port-level checker for the IR RGB LED mode controller, with its bind.
module irled_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red_duty,
  input logic [7:0] out_green_duty,
  input logic [7:0] out_blue_duty,
  input logic       out_code_matched,
  input logic       out_fading_active,
  input logic       cfg_ready
);

  // No result is offered in the cycle after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side stalls only when a result is waiting and not taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // A stalled result holds its transfer payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_duty) &&
      $stable(out_green_duty) && $stable(out_blue_duty) &&
      $stable(out_code_matched) && $stable(out_fading_active))
    else $error("stalled result changed");

  // An accepted item leads to a result offered on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item lost");

  // Configuration writes are never refused.
  assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration write refused");

endmodule

bind ir_rgb_led_mode_controller_core irled_checker u_irled_checker (.*);

[bench/tb_ir_rgb_led_mode_controller_core.sv]
// Self-checking testbench for the IR RGB LED mode controller core.
`timescale 1ns / 1ps

module tb_ir_rgb_led_mode_controller_core;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TIMEOUT_NS  = 2_000_000;

  // Table keys without the fade key, which the random traffic issues on its own terms.
  localparam logic [15:0] PLAIN_KEYS [20] = '{
    irled_pkg::KEY_ON, irled_pkg::KEY_OFF, irled_pkg::KEY_YELLOW, irled_pkg::KEY_BLUE,
    irled_pkg::KEY_PINK, irled_pkg::KEY_LILAC, irled_pkg::KEY_TEAL, irled_pkg::KEY_ORANGE,
    irled_pkg::KEY_MAGENTA, irled_pkg::KEY_CYAN, irled_pkg::KEY_AMBER,
    irled_pkg::KEY_PURPLE, irled_pkg::KEY_MINT, irled_pkg::KEY_CORAL,
    irled_pkg::KEY_WHITE_W, irled_pkg::KEY_STROBE, irled_pkg::KEY_SMOOTH,
    irled_pkg::KEY_FLASH, irled_pkg::KEY_DIM, irled_pkg::KEY_BRIGHT
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_operation = irled_pkg::OPER_TICK;
  logic [15:0]                     in_key_code = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      out_red_duty;
  logic [7:0]                      out_green_duty;
  logic [7:0]                      out_blue_duty;
  logic                            out_code_matched;
  logic                            out_fading_active;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [irled_pkg::CFG_IDX_W-1:0] cfg_index = irled_pkg::CFG_BRIGHTNESS_STEP;
  logic [15:0]                     cfg_data = '0;

  // Shadow of the controller state, advanced once per accepted item.
  irled_pkg::cfg_t  cfg;
  irled_pkg::mode_t modes;
  logic [7:0]       lvl [3];
  logic [2:0]       dir;
  logic             flash_phase;
  logic [15:0]      smooth_cnt;
  logic [15:0]      flash_cnt;
  logic [15:0]      fade_cnt;

  irled_pkg::result_t pending_leds [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned leds_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;

  ir_rgb_led_mode_controller_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_key_code       (in_key_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_duty      (out_red_duty),
    .out_green_duty    (out_green_duty),
    .out_blue_duty     (out_blue_duty),
    .out_code_matched  (out_code_matched),
    .out_fading_active (out_fading_active),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  function automatic void set_levels(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    lvl[0] = r;
    lvl[1] = g;
    lvl[2] = b;
  endfunction

  function automatic logic levels_black();
    return (lvl[0] == 8'd0) && (lvl[1] == 8'd0) && (lvl[2] == 8'd0);
  endfunction

  // Apply one item to the shadow state and return the duty values it should produce.
  function automatic irled_pkg::result_t next_led_result(logic op, logic [15:0] code);
    irled_pkg::result_t res;
    logic               hit;
    logic [8:0]         sum;
    hit = 1'b0;
    if (op == irled_pkg::OPER_TICK) begin
      if (smooth_cnt != irled_pkg::CNT_MAX) smooth_cnt++;
      if (flash_cnt != irled_pkg::CNT_MAX) flash_cnt++;
      if (flash_cnt >= cfg.flash_half_period) begin
        flash_cnt = '0;
        flash_phase = ~flash_phase;
      end
      // Triangle step: a channel at its end turns around and holds for this step.
      if (modes.smooth && !modes.fade && smooth_cnt >= cfg.smooth_period) begin
        smooth_cnt = '0;
        for (int i = 0; i < 3; i++) begin
          if (dir[i]) begin
            if (lvl[i] == irled_pkg::LEVEL_MAX) dir[i] = 1'b0;
            else lvl[i]++;
          end else begin
            if (lvl[i] == 8'd0) dir[i] = 1'b1;
            else lvl[i]--;
          end
        end
      end
      if (modes.fade) begin
        if (fade_cnt != irled_pkg::CNT_MAX) fade_cnt++;
        if (fade_cnt >= cfg.fade_period) begin
          fade_cnt = '0;
          for (int i = 0; i < 3; i++) begin
            if (lvl[i] != 8'd0) lvl[i]--;
          end
        end
        if (levels_black()) modes.fade = 1'b0;
      end
    end else if (!modes.fade) begin
      // Keys are dropped entirely while a fade runs.
      hit = 1'b1;
      case (code)
        irled_pkg::KEY_ON:      set_levels(255, 255, 255);
        irled_pkg::KEY_OFF: begin
          set_levels(0, 0, 0);
          modes.flash = 1'b0;
          modes.smooth = 1'b0;
        end
        irled_pkg::KEY_YELLOW:  set_levels(255, 246, 0);
        irled_pkg::KEY_BLUE:    set_levels(0, 0, 255);
        irled_pkg::KEY_PINK:    set_levels(255, 219, 232);
        irled_pkg::KEY_LILAC:   set_levels(209, 117, 255);
        irled_pkg::KEY_TEAL:    set_levels(0, 117, 175);
        irled_pkg::KEY_ORANGE:  set_levels(255, 153, 0);
        irled_pkg::KEY_MAGENTA: set_levels(255, 0, 255);
        irled_pkg::KEY_CYAN:    set_levels(0, 203, 255);
        irled_pkg::KEY_AMBER:   set_levels(255, 110, 0);
        irled_pkg::KEY_PURPLE:  set_levels(116, 37, 252);
        irled_pkg::KEY_MINT:    set_levels(38, 255, 139);
        irled_pkg::KEY_CORAL:   set_levels(255, 58, 58);
        irled_pkg::KEY_WHITE_W: ;
        irled_pkg::KEY_STROBE: begin
          modes.flash = 1'b0;
          modes.smooth = 1'b0;
          modes.strobe = 1'b1;
          set_levels(0, 0, 255);
        end
        irled_pkg::KEY_FADE: begin
          if (!levels_black()) begin
            modes.fade = 1'b1;
            fade_cnt = '0;
          end
        end
        irled_pkg::KEY_SMOOTH: begin
          modes.smooth = ~modes.smooth;
          if (modes.smooth && levels_black()) set_levels(116, 37, 252);
        end
        irled_pkg::KEY_FLASH: begin
          modes.strobe = 1'b0;
          modes.flash = ~modes.flash;
          if (modes.flash && levels_black()) set_levels(255, 255, 255);
        end
        irled_pkg::KEY_DIM: begin
          for (int i = 0; i < 3; i++)
            lvl[i] = (lvl[i] > cfg.brightness_step) ? lvl[i] - cfg.brightness_step : 8'd0;
        end
        irled_pkg::KEY_BRIGHT: begin
          for (int i = 0; i < 3; i++) begin
            sum = lvl[i] + cfg.brightness_step;
            lvl[i] = (sum > irled_pkg::LEVEL_MAX) ? irled_pkg::LEVEL_MAX : sum[7:0];
          end
        end
        default: hit = 1'b0;
      endcase
    end
    // Flash blanks and strobe shows full red on the odd half-period.
    if ((modes.flash || modes.strobe) && flash_phase) begin
      res.red   = modes.strobe ? irled_pkg::LEVEL_MAX : 8'd0;
      res.green = 8'd0;
      res.blue  = 8'd0;
    end else begin
      res.red   = lvl[0];
      res.green = lvl[1];
      res.blue  = lvl[2];
    end
    res.code_matched  = hit;
    res.fading_active = modes.fade;
    return res;
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Result checker: every transfer on the output is matched against the oldest prediction.
  always @(posedge clk) begin
    irled_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_leds.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, actual %0d/%0d/%0d", $time,
                 out_red_duty, out_green_duty, out_blue_duty);
      end else begin
        want = pending_leds.pop_front();
        compare_field("red_duty", want.red, out_red_duty);
        compare_field("green_duty", want.green, out_green_duty);
        compare_field("blue_duty", want.blue, out_blue_duty);
        compare_field("code_matched", want.code_matched, out_code_matched);
        compare_field("fading_active", want.fading_active, out_fading_active);
        leds_checked++;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item, wait for its transfer and record the predicted result.
  task automatic offer_item(logic op, logic [15:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key_code <= code;
    do @(posedge clk); while (!in_ready);
    pending_leds.push_back(next_led_result(op, code));
    items_sent++;
  endtask

  task automatic offer_ticks(int unsigned count);
    repeat (count) offer_item(irled_pkg::OPER_TICK, 16'($urandom));
  endtask

  // Mostly ticks and table keys; fade only from dim colors so it ends in reasonable time.
  task automatic offer_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (modes.fade ? (pick < 90) : (pick < 42))
      offer_ticks(1);
    else if (pick < 46)
      offer_item(irled_pkg::OPER_KEY,
                 (lvl[0] < 96 && lvl[1] < 96 && lvl[2] < 96) ? irled_pkg::KEY_FADE
                                                             : irled_pkg::KEY_DIM);
    else if (pick < 90)
      offer_item(irled_pkg::OPER_KEY, PLAIN_KEYS[$urandom_range(19)]);
    else
      offer_item(irled_pkg::OPER_KEY, 16'($urandom));
  endtask

  // Stop offering and let every outstanding result come out.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [irled_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      irled_pkg::CFG_BRIGHTNESS_STEP:   cfg.brightness_step = data[7:0];
      irled_pkg::CFG_SMOOTH_PERIOD:     cfg.smooth_period = data;
      irled_pkg::CFG_FLASH_HALF_PERIOD: cfg.flash_half_period = data;
      irled_pkg::CFG_FADE_PERIOD:       cfg.fade_period = data;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every key action with the reset register values, including unknown codes.
  task automatic test_key_actions();
    offer_item(irled_pkg::OPER_KEY, 16'h0000);
    offer_item(irled_pkg::OPER_KEY, 16'hFFFF);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FADE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_ON);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_BRIGHT);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_DIM);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_YELLOW);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_BLUE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_PINK);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_LILAC);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_TEAL);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_ORANGE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_MAGENTA);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_CYAN);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_AMBER);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_PURPLE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_MINT);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_CORAL);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_WHITE_W);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_STROBE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FLASH);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_SMOOTH);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_OFF);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_SMOOTH);
    offer_ticks(1);
  endtask

  // Register extremes: saturating brightness steps, zero and full-scale periods.
  task automatic test_register_extremes();
    settle_block();
    write_register(irled_pkg::CFG_BRIGHTNESS_STEP, 16'd255);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_ON);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_DIM);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_BRIGHT);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_DIM);
    settle_block();
    write_register(irled_pkg::CFG_BRIGHTNESS_STEP, 16'd0);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_CORAL);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_BRIGHT);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_DIM);

    // Zero periods fire on every tick.
    settle_block();
    write_register(irled_pkg::CFG_SMOOTH_PERIOD, 16'd0);
    write_register(irled_pkg::CFG_FLASH_HALF_PERIOD, 16'd0);
    write_register(irled_pkg::CFG_FADE_PERIOD, 16'd0);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_OFF);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_SMOOTH);
    offer_ticks(4);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_STROBE);
    offer_ticks(3);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FLASH);
    offer_ticks(3);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FLASH);

    // A short fade with a key that must be ignored while it runs.
    settle_block();
    write_register(irled_pkg::CFG_BRIGHTNESS_STEP, 16'd250);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_DIM);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FADE);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_ON);
    while (modes.fade) offer_ticks(1);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FADE);

    // Full-scale periods keep the timed events from firing.
    settle_block();
    write_register(irled_pkg::CFG_BRIGHTNESS_STEP, 16'd1);
    write_register(irled_pkg::CFG_SMOOTH_PERIOD, 16'hFFFF);
    write_register(irled_pkg::CFG_FLASH_HALF_PERIOD, 16'hFFFF);
    write_register(irled_pkg::CFG_FADE_PERIOD, 16'hFFFF);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_SMOOTH);
    offer_ticks(5);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_BRIGHT);
    offer_item(irled_pkg::OPER_KEY, irled_pkg::KEY_FLASH);
    offer_ticks(3);
  endtask

  task automatic load_random_setting();
    settle_block();
    write_register(irled_pkg::CFG_BRIGHTNESS_STEP, 16'($urandom_range(255)));
    write_register(irled_pkg::CFG_SMOOTH_PERIOD, 16'($urandom_range(8, 1)));
    write_register(irled_pkg::CFG_FLASH_HALF_PERIOD, 16'($urandom_range(30, 1)));
    write_register(irled_pkg::CFG_FADE_PERIOD, 16'($urandom_range(2, 1)));
  endtask

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned count);
    load_random_setting();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) offer_random_item();
  endtask

  // Output held off for a long stretch while input keeps coming, so the core backs up.
  task automatic test_output_backpressure();
    load_random_setting();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (40) offer_random_item();
  endtask

  initial begin
    cfg.brightness_step   = irled_pkg::RST_BRIGHTNESS_STEP;
    cfg.smooth_period     = irled_pkg::RST_SMOOTH_PERIOD;
    cfg.flash_half_period = irled_pkg::RST_FLASH_HALF_PERIOD;
    cfg.fade_period       = irled_pkg::RST_FADE_PERIOD;
    modes       = '0;
    dir         = 3'b111;
    flash_phase = 1'b0;
    smooth_cnt  = '0;
    flash_cnt   = '0;
    fade_cnt    = '0;
    set_levels(0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_key_actions();
    test_register_extremes();
    test_random_traffic(0, 0, 200);
    test_random_traffic(59, 0, 200);
    test_random_traffic(0, 59, 200);
    test_random_traffic(34, 34, 200);
    test_output_backpressure();

    settle_block();
    repeat (8) @(posedge clk);
    $display("Run covered %0d items (%0d results checked) and %0d register writes,",
             items_sent, leds_checked, cfg_writes);
    $display("with all key actions, zero and full-scale periods, and a long output hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
